// ===== src/hre_pkg.sv =====
// Package for the hex record encoder: shared types, codes and character helpers.
// Depends on nothing; every module of the block imports it.
package hre_pkg;

    localparam logic [1:0] OP_DATA = 2'd0;
    localparam logic [1:0] OP_ADDR = 2'd1;
    localparam logic [1:0] OP_HEAD = 2'd2;
    localparam logic [1:0] OP_TAIL = 2'd3;

    localparam logic [1:0] MODE_SREC  = 2'd0;
    localparam logic [1:0] MODE_IHEX  = 2'd1;

    localparam logic [0:0] REG_FORMAT = 1'b0;
    localparam logic [0:0] REG_LIMIT  = 1'b1;

    // Kind of text job handed from the front part to the back part.
    typedef enum logic [3:0] {
        JOB_RAW  = 4'b0001,
        JOB_DATA = 4'b0010,
        JOB_FIX  = 4'b0100,
        JOB_NONE = 4'b1000
    } job_kind_t;

    // Fixed lines: S0, S9 and the Intel end-of-file record.
    localparam logic [1:0] FIX_S0  = 2'd0;
    localparam logic [1:0] FIX_S9  = 2'd1;
    localparam logic [1:0] FIX_EOF = 2'd2;

    // One classified transaction. The back part expands it into characters.
    typedef struct packed {
        job_kind_t   kind;
        logic [1:0]  fix_sel;
        logic        srec;
        logic        open_rec;   // record header precedes the byte
        logic        ext_rec;    // Intel extended linear address record first
        logic        wide;       // S3 rather than S1
        logic [7:0]  cnt;        // count field of the record header
        logic [31:0] addr;
        logic [7:0]  data;
        logic        close_rec;  // checksum and line end follow the byte
        logic [7:0]  csum;
        logic [7:0]  ext_csum;
        logic        ovf;
    } job_t;

    function automatic logic [7:0] hex_char(input logic [3:0] v);
        hex_char = (v < 4'd10) ? (8'h30 + {4'd0, v}) : (8'h37 + {4'd0, v});
    endfunction

    function automatic logic [7:0] fix_char(input logic [1:0] sel, input logic [4:0] i);
        logic [7:0] c;
        c = 8'h0A;
        case (sel)
            FIX_S0: begin
                case (i)
                    5'd0: c = "S"; 5'd1: c = "0"; 5'd2: c = "0"; 5'd3: c = "6";
                    5'd4: c = "0"; 5'd5: c = "0"; 5'd6: c = "0"; 5'd7: c = "0";
                    5'd8: c = "4"; 5'd9: c = "8"; 5'd10: c = "4"; 5'd11: c = "4";
                    5'd12: c = "5"; 5'd13: c = "2"; 5'd14: c = "1"; 5'd15: c = "B";
                    5'd16: c = 8'h0D;
                    default: c = 8'h0A;
                endcase
            end
            FIX_S9: begin
                case (i)
                    5'd0: c = "S"; 5'd1: c = "9"; 5'd2: c = "0"; 5'd3: c = "3";
                    5'd4: c = "0"; 5'd5: c = "0"; 5'd6: c = "0"; 5'd7: c = "0";
                    5'd8: c = "F"; 5'd9: c = "C"; 5'd10: c = 8'h0D;
                    default: c = 8'h0A;
                endcase
            end
            default: begin
                case (i)
                    5'd0: c = ":"; 5'd1: c = "0"; 5'd2: c = "0"; 5'd3: c = "0";
                    5'd4: c = "0"; 5'd5: c = "0"; 5'd6: c = "0"; 5'd7: c = "0";
                    5'd8: c = "1"; 5'd9: c = "F"; 5'd10: c = "F"; 5'd11: c = 8'h0D;
                    default: c = 8'h0A;
                endcase
            end
        endcase
        fix_char = c;
    endfunction

    function automatic logic [4:0] fix_len(input logic [1:0] sel);
        case (sel)
            FIX_S0:  fix_len = 5'd18;
            FIX_S9:  fix_len = 5'd12;
            default: fix_len = 5'd13;
        endcase
    endfunction

endpackage

// ===== src/hre_front.sv =====
// Front part of the hex record encoder: holds the stream state and classifies
// each input transaction into one text job. Depends on hre_pkg.
module hre_front
    import hre_pkg::*;
#(
    parameter int MAX_RECORD = 255
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        in_fire,
    input  logic [1:0]  op,
    input  logic [7:0]  data_byte,
    input  logic [7:0]  record_bytes,
    input  logic [31:0] new_address,
    input  logic        cfg_fire,
    input  logic        cfg_index,
    input  logic [31:0] cfg_data,
    output job_t        job
);

    localparam logic [7:0] LIM_ALL  = 8'(MAX_RECORD);
    localparam logic [7:0] LIM_SREC = (MAX_RECORD > 250) ? 8'd250 : 8'(MAX_RECORD);

    logic [1:0]  mode_reg;
    logic [31:0] limit_reg;
    logic [31:0] addr_reg;
    logic [15:0] upper_reg;
    logic [7:0]  left_reg;
    logic [7:0]  rest_reg;
    logic [7:0]  sum_reg;
    logic [32:0] used_reg;

    logic        raw, srec, opening;
    logic [7:0]  n, lim, chunk, chunk0, left_next, sum_open, sum_next, cnt;
    logic [31:0] endv;
    logic [16:0] to_bound;
    logic [32:0] used_next;
    logic [7:0]  ext_s;

    always_comb begin
        raw     = mode_reg[1];
        srec    = (mode_reg == MODE_SREC);
        opening = (left_reg == 8'd0);
        n       = (rest_reg != 8'd0) ? rest_reg : record_bytes;
        if (n == 8'd0) n = 8'd1;
        lim     = srec ? LIM_SREC : LIM_ALL;
        chunk0  = (n < lim) ? n : lim;
        endv    = addr_reg + {24'd0, chunk0};
        to_bound = 17'h10000 - {1'b0, addr_reg[15:0]};
        chunk   = chunk0;
        if (!srec && ((addr_reg[31:16] ^ endv[31:16]) != 16'd0) && (endv[15:0] != 16'd0))
            chunk = to_bound[7:0];
        if (srec)
            cnt = chunk + ((addr_reg > 32'hFFFF) ? 8'd5 : 8'd3);
        else
            cnt = chunk;
        if (srec)
            sum_open = cnt + addr_reg[7:0] + addr_reg[15:8] + addr_reg[23:16]
                     + addr_reg[31:24];
        else
            sum_open = cnt + addr_reg[7:0] + addr_reg[15:8];
        sum_next  = (opening ? sum_open : sum_reg) + data_byte;
        left_next = (opening ? chunk : left_reg) - 8'd1;
        ext_s     = 8'd6 + addr_reg[23:16] + addr_reg[31:24];
        used_next = (used_reg == {33{1'b1}}) ? used_reg : used_reg + 33'd1;
    end

    // Job for the current input transaction.
    always_comb begin
        job           = '0;
        job.kind      = JOB_NONE;
        job.srec      = srec;
        job.open_rec  = opening;
        job.ext_rec   = !srec && opening && (addr_reg[31:16] != upper_reg);
        job.wide      = addr_reg > 32'hFFFF;
        job.cnt       = cnt;
        job.addr      = addr_reg;
        job.data      = data_byte;
        job.close_rec = (left_next == 8'd0);
        job.csum      = srec ? ~sum_next : (8'd0 - sum_next);
        job.ext_csum  = 8'd0 - ext_s;
        job.fix_sel   = (op == OP_HEAD) ? FIX_S0 : (srec ? FIX_S9 : FIX_EOF);
        case (op)
            OP_DATA: job.kind = raw ? JOB_RAW : JOB_DATA;
            OP_ADDR: job.kind = JOB_NONE;
            default: begin
                if (!raw && opening && (srec || op == OP_TAIL))
                    job.kind = JOB_FIX;
            end
        endcase
        if (op == OP_DATA)
            job.ovf = (limit_reg != 32'd0) && (used_next > {1'b0, limit_reg});
        else
            job.ovf = (limit_reg != 32'd0) && (used_reg > {1'b0, limit_reg});
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= MODE_SREC;
            limit_reg <= '0;
            addr_reg  <= '0;
            upper_reg <= '0;
            left_reg  <= '0;
            rest_reg  <= '0;
            sum_reg   <= '0;
            used_reg  <= '0;
        end else if (cfg_fire) begin
            if (cfg_index == REG_FORMAT) begin
                mode_reg <= cfg_data[1:0];
                left_reg <= '0;
                rest_reg <= '0;
                sum_reg  <= '0;
            end else begin
                limit_reg <= cfg_data;
            end
        end else if (in_fire) begin
            if (op == OP_DATA) begin
                addr_reg <= addr_reg + 32'd1;
                used_reg <= used_next;
                if (!raw) begin
                    left_reg <= left_next;
                    sum_reg  <= sum_next;
                    if (opening) begin
                        rest_reg <= n - chunk;
                        if (!srec) upper_reg <= addr_reg[31:16];
                    end
                end
            end else if (op == OP_ADDR) begin
                addr_reg <= new_address;
            end
        end
    end

endmodule

// ===== src/hre_queue.sv =====
// Small job queue between the front and back parts of the hex record encoder.
// Depends on hre_pkg for the job type.
module hre_queue
    import hre_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  job_t push_job,
    output logic full,
    input  logic pop,
    output logic nonempty,
    output job_t head
);

    job_t       mem_reg [2];
    logic [1:0] wp_reg, rp_reg;

    assign nonempty = (wp_reg != rp_reg);
    assign full     = (wp_reg[0] == rp_reg[0]) && (wp_reg[1] != rp_reg[1]);
    assign head     = mem_reg[rp_reg[0]];

    always_ff @(posedge aclk) begin
        if (push) mem_reg[wp_reg[0]] <= push_job;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg <= '0;
            rp_reg <= '0;
        end else begin
            if (push) wp_reg <= wp_reg + 2'd1;
            if (pop)  rp_reg <= rp_reg + 2'd1;
        end
    end

endmodule

// ===== src/hre_back.sv =====
// Back part of the hex record encoder: expands a job into characters, one per
// cycle unless stalled, into a registered output stage. Depends on hre_pkg.
module hre_back
    import hre_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       job_valid,
    input  job_t       job,
    output logic       job_pop,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_char_out,
    output logic       m_last,
    output logic       m_overflow
);

    logic [4:0] pos_reg;
    logic [7:0] ch;
    logic       item_end;
    logic       out_free, adv;
    logic [7:0] hdr_len;

    // pos_reg counts through the whole job; the section follows from it.
    logic [4:0] p;
    logic [4:0] base_hdr, base_data, total;
    logic [7:0] hb;
    always_comb begin
        p         = pos_reg;
        base_hdr  = job.ext_rec ? 5'd17 : 5'd0;
        hdr_len   = job.srec ? (job.wide ? 8'd12 : 8'd8) : 8'd9;
        base_data = job.open_rec ? (base_hdr + hdr_len[4:0]) : 5'd0;
        total     = base_data + (job.close_rec ? 5'd6 : 5'd2);
        if (job.kind == JOB_RAW)      total = 5'd1;
        else if (job.kind == JOB_FIX) total = fix_len(job.fix_sel);
        ch = job.data;
        hb = 8'd0;
        case (job.kind)
            JOB_RAW: ch = job.data;
            JOB_FIX: ch = fix_char(job.fix_sel, p);
            default: begin
                if (job.ext_rec && p < 5'd17) begin
                    case (p)
                        5'd0: ch = ":";
                        5'd8: ch = "4"; 5'd2: ch = "2";
                        5'd9: ch = hex_char(job.addr[31:28]);
                        5'd10: ch = hex_char(job.addr[27:24]);
                        5'd11: ch = hex_char(job.addr[23:20]);
                        5'd12: ch = hex_char(job.addr[19:16]);
                        5'd13: ch = hex_char(job.ext_csum[7:4]);
                        5'd14: ch = hex_char(job.ext_csum[3:0]);
                        5'd15: ch = 8'h0D;
                        5'd16: ch = 8'h0A;
                        default: ch = "0";
                    endcase
                end else if (job.open_rec && p < base_data) begin
                    hb = {3'd0, p - base_hdr};
                    if (job.srec) begin
                        case (hb[3:0])
                            4'd0: ch = "S";
                            4'd1: ch = job.wide ? "3" : "1";
                            4'd2: ch = hex_char(job.cnt[7:4]);
                            4'd3: ch = hex_char(job.cnt[3:0]);
                            default: begin
                                // Address digits, most significant first.
                                if (job.wide)
                                    ch = hex_char(job.addr[6'd31 - {hb[3:0] - 4'd4, 2'b00} -: 4]);
                                else
                                    ch = hex_char(job.addr[6'd15 - {hb[3:0] - 4'd4, 2'b00} -: 4]);
                            end
                        endcase
                    end else begin
                        case (hb[3:0])
                            4'd0: ch = ":";
                            4'd1: ch = hex_char(job.cnt[7:4]);
                            4'd2: ch = hex_char(job.cnt[3:0]);
                            4'd7, 4'd8: ch = "0";
                            default: ch = hex_char(job.addr[6'd15 - {hb[3:0] - 4'd3, 2'b00} -: 4]);
                        endcase
                    end
                end else begin
                    case (p - base_data)
                        5'd0: ch = hex_char(job.data[7:4]);
                        5'd1: ch = hex_char(job.data[3:0]);
                        5'd2: ch = hex_char(job.csum[7:4]);
                        5'd3: ch = hex_char(job.csum[3:0]);
                        5'd4: ch = 8'h0D;
                        default: ch = 8'h0A;
                    endcase
                end
            end
        endcase
        item_end = (p == total - 5'd1);
    end

    assign out_free = !m_valid || m_ready;
    assign adv      = job_valid && out_free && (job.kind != JOB_NONE);
    assign job_pop  = job_valid && ((job.kind == JOB_NONE) || (adv && item_end));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg <= '0;
            m_valid <= 1'b0;
        end else begin
            if (out_free) m_valid <= adv;
            if (adv) pos_reg <= item_end ? 5'd0 : pos_reg + 5'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            m_char_out <= ch;
            m_last     <= item_end;
            m_overflow <= job.ovf;
        end
    end

endmodule

// ===== src/hex_record_encoder.sv =====
// Top level of the hex record encoder: front classifier, job queue and
// character back end. Depends on hre_pkg, hre_front, hre_queue, hre_back.
//
//   Channel | Ports                                   | Direction
//   input   | s_valid s_ready s_op s_data_byte ...    | in
//   result  | m_valid m_ready m_char_out m_last ...   | out
//   config  | cfg_valid cfg_ready cfg_index cfg_data  | in
//
// The back end emits one character per cycle while the output is not stalled,
// so a data byte in the middle of a record gives two characters; headers and
// fixed lines go out character by character (up to 32 characters, for an Intel
// byte that opens and closes a record behind an extended address record). The
// front takes one transaction per cycle while the two-entry job queue has room
// and no configuration write is pending. Reset is synchronous and active low
// and clears stream state, queue pointers and m_valid. Either side may stall.
module hex_record_encoder
    import hre_pkg::*;
#(
    parameter int MAX_RECORD = 255
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_op,
    input  logic [7:0]  s_data_byte,
    input  logic [7:0]  s_record_bytes,
    input  logic [31:0] s_new_address,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_char_out,
    output logic        m_last,
    output logic        m_overflow,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [31:0] cfg_data
);

    job_t job_in, job_head;
    logic q_full, q_nonempty, q_pop, in_fire, cfg_fire;

    // Configuration writes are always taken and have priority over input transactions.
    assign cfg_ready = 1'b1;
    assign cfg_fire  = cfg_valid;
    assign s_ready   = !q_full && !cfg_valid;
    assign in_fire   = s_valid && s_ready;

    hre_front #(.MAX_RECORD(MAX_RECORD)) u_front (
        .aclk, .aresetn, .in_fire,
        .op(s_op), .data_byte(s_data_byte), .record_bytes(s_record_bytes),
        .new_address(s_new_address),
        .cfg_fire, .cfg_index, .cfg_data,
        .job(job_in)
    );

    hre_queue u_queue (
        .aclk, .aresetn, .push(in_fire), .push_job(job_in), .full(q_full),
        .pop(q_pop), .nonempty(q_nonempty), .head(job_head)
    );

    hre_back u_back (
        .aclk, .aresetn, .job_valid(q_nonempty), .job(job_head), .job_pop(q_pop),
        .m_valid, .m_ready, .m_char_out, .m_last, .m_overflow
    );

    // The queue never takes a job while full.
    assert property (@(posedge aclk) disable iff (!aresetn) q_full |-> !in_fire)
        else $error("push into full job queue");

    // A pop without a push always leaves room in the queue.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (q_pop && !in_fire) |=> !q_full)
        else $error("queue full after pop without push");

    // No transaction is taken in the same cycle as a configuration write.
    assert property (@(posedge aclk) disable iff (!aresetn) cfg_fire |-> !in_fire)
        else $error("input accepted during configuration write");

endmodule
